>>> sv/cubic_bezier_tessellator_defines.svh
// Assertion macros for the cubic Bezier tessellator.
`ifndef CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH
`define CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bezt_pkg.sv
// Types, widths and helpers shared by the Bezier tessellator modules.
package bezt_pkg;

  localparam int COORD_W  = 24;
  localparam int CF_W     = COORD_W + 6;
  localparam int T_W      = 17;
  localparam int TB_W     = T_W + 1;
  localparam int PROD_W   = CF_W + TB_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int CNT_W    = 7;
  localparam int DIVD_W   = 18;
  localparam logic [DIVD_W-1:0] DIVIDEND = 18'h20000;
  localparam logic [CNT_W-1:0]  SPP_RESET = 7'd16;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic                      segment_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      span_last;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COEF = 5'b00010,
    S_DIV  = 5'b00100,
    S_EVAL = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

>>> sv/bezt_mul.sv
// Shared signed multiplier with a registered product.
module bezt_mul (
  input  logic                                 clk,
  input  logic signed [bezt_pkg::CF_W-1:0]     op_a,
  input  logic signed [bezt_pkg::TB_W-1:0]     op_b,
  output logic signed [bezt_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> sv/bezt_div.sv
// Restoring divider: the per-sample t step as quotient and remainder of 2^17 / divisor.
module bezt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [7:0]                  divisor,
  output logic                        done_r,
  output logic [bezt_pkg::T_W-1:0]    quo,
  output logic [7:0]                  rem_r
);

  logic [bezt_pkg::DIVD_W-1:0] quo_r;
  logic [4:0]                  cnt_r;
  logic                        busy_r;
  logic [8:0]                  sh;
  logic                        fits;

  assign sh   = {rem_r, quo_r[bezt_pkg::DIVD_W-1]};
  assign fits = sh >= {1'b0, divisor};
  assign quo  = quo_r[bezt_pkg::T_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(bezt_pkg::DIVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= bezt_pkg::DIVIDEND;
    end else if (busy_r) begin
      rem_r <= fits ? 8'(sh - {1'b0, divisor}) : sh[7:0];
      quo_r <= {quo_r[bezt_pkg::DIVD_W-2:0], fits};
    end
  end

endmodule

>>> sv/cubic_bezier_tessellator.sv
// Cubic Bezier tessellator: control points in, evenly spaced curve samples out.
//
// Input channel (in_valid/in_stall/in_data) carries one 3-D control point a beat.
// A beat with segment_start opens a segment as its anchor; each further three
// beats complete a span, and the span's end becomes the next anchor. Beats
// without an open segment are dropped. Configuration: cfg_we/cfg_wdata write
// samples_per_span (clamped to 2..MAX_SAMPLES); write only while idle.
// Output channel (out_valid/out_stall/out_data) gives n samples per span,
// span_last set on the final one.
// A point that does not complete a span leaves the input open for the next
// point. A completing point runs coefficient setup alongside the step division,
// and sample evaluation starts once the division is done. Each sample then uses
// the shared multiplier for eleven products (t^2, t^3 and three per axis)
// before it is handed off. in_stall stays high from the completing accept
// until the span's last sample is taken.
// A stalled output sample holds its register and the sequencer waits on it.
// Reset (rst_n, synchronous) closes any open segment and sets n to 16.
`include "cubic_bezier_tessellator_defines.svh"
module cubic_bezier_tessellator #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bezt_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bezt_pkg::out_beat_t   out_data,
  input  logic                  cfg_we,
  input  logic [bezt_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int CW    = bezt_pkg::COORD_W;
  localparam int CF    = bezt_pkg::CF_W;
  localparam int TW    = bezt_pkg::T_W;
  localparam int PW    = bezt_pkg::PROD_W;
  localparam int SW    = bezt_pkg::SUM_W;
  localparam int NW    = bezt_pkg::CNT_W;
  localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

  bezt_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]          spp_r;
  logic [1:0]             psa_r, psa_nxt;
  logic                   anchor_r, anchor_nxt;
  logic [1:0]             ax_r, ax_nxt;
  logic [4:0]             step_r, step_nxt;
  logic [IDX_W-1:0]       i_r, i_nxt;
  logic [TW-1:0]          q_r, q_nxt;
  logic [7:0]             r_r, r_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic signed [CW-1:0]   pt_r [4][3];
  logic signed [CF-1:0]   ca_r [3];
  logic signed [CF-1:0]   cb_r [3];
  logic signed [CF-1:0]   cc_r [3];
  logic [TW-1:0]          t2_r, t3_r;
  logic signed [SW-1:0]   acc_r, sum_r;
  bezt_pkg::out_beat_t    out_r;

  logic [NW-1:0]          n_eff, den;
  logic [7:0]             d2;
  logic                   in_acc, out_acc, span_done, is_last;
  logic [1:0]             slot;
  logic [2:0]             grp;
  logic [1:0]             ph;
  logic [1:0]             max;
  logic signed [CF-1:0]   op_a;
  logic signed [bezt_pkg::TB_W-1:0] op_b;
  logic signed [PW-1:0]   prod_r;
  logic [TW-1:0]          prod_rnd;
  logic                   div_done;
  logic [TW-1:0]          div_quo;
  logic [7:0]             div_rem;
  logic [8:0]             r_sum;
  logic                   r_over;
  logic signed [CF-1:0]   e0, e1, e2, e3, d10, d21, c_v, b_v, a_v;
  logic signed [SW-1:0]   rnd_sum, fin_v;
  logic signed [CW-1:0]   fin_sat;

  // Sample count, clamped.
  always_comb begin
    if (spp_r < NW'(2)) begin
      n_eff = NW'(2);
    end else if (spp_r > NW'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = spp_r;
    end
  end
  assign den     = n_eff - NW'(1);
  assign d2      = {den, 1'b0};
  assign is_last = NW'(i_r) == den;

  assign in_stall  = state_r != bezt_pkg::S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && !out_stall;

  assign slot      = (psa_r == 2'd3) ? 2'd3 : psa_r + 2'd1;
  assign span_done = in_acc && !in_data.segment_start && anchor_r && slot == 2'd3;

  assign grp = step_r[4:2];
  assign ph  = step_r[1:0];
  assign max = 2'(grp - 3'd1);

  // Coefficients for one axis.
  always_comb begin
    e0  = CF'(pt_r[0][ax_r]);
    e1  = CF'(pt_r[1][ax_r]);
    e2  = CF'(pt_r[2][ax_r]);
    e3  = CF'(pt_r[3][ax_r]);
    d10 = e1 - e0;
    d21 = e2 - e1;
    c_v = d10 + (d10 <<< 1);
    b_v = d21 + (d21 <<< 1) - c_v;
    a_v = e3 - e0 - c_v - b_v;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == bezt_pkg::S_EVAL) begin
      if (grp == 3'd0) begin
        case (ph)
          2'd0: begin
            op_a = $signed(CF'(q_r));
            op_b = $signed({1'b0, q_r});
          end
          2'd2: begin
            op_a = $signed(CF'(t2_r));
            op_b = $signed({1'b0, q_r});
          end
          default: begin
            op_a = '0;
            op_b = '0;
          end
        endcase
      end else if (grp <= 3'd3) begin
        case (ph)
          2'd0: begin
            op_a = ca_r[max];
            op_b = $signed({1'b0, t3_r});
          end
          2'd1: begin
            op_a = cb_r[max];
            op_b = $signed({1'b0, t2_r});
          end
          2'd2: begin
            op_a = cc_r[max];
            op_b = $signed({1'b0, q_r});
          end
          default: begin
            op_a = '0;
            op_b = '0;
          end
        endcase
      end
    end
  end

  bezt_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  bezt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (span_done),
    .divisor (d2),
    .done_r  (div_done),
    .quo     (div_quo),
    .rem_r   (div_rem)
  );

  assign prod_rnd = TW'((prod_r + PW'(32768)) >>> 16);
  assign rnd_sum  = (sum_r + SW'(32768)) >>> 16;
  assign fin_v    = rnd_sum + SW'(pt_r[0][2'(grp - 3'd2)]);
  assign fin_sat  = bezt_pkg::sat_coord(fin_v);

  assign r_sum  = {1'b0, r_r} + {1'b0, div_rem};
  assign r_over = r_sum >= {1'b0, d2};

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    psa_nxt       = psa_r;
    anchor_nxt    = anchor_r;
    ax_nxt        = ax_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      bezt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.segment_start) begin
            psa_nxt    = 2'd0;
            anchor_nxt = 1'b1;
          end else if (anchor_r) begin
            psa_nxt = slot;
            if (slot == 2'd3) begin
              psa_nxt   = 2'd0;
              ax_nxt    = 2'd0;
              step_nxt  = '0;
              i_nxt     = '0;
              q_nxt     = '0;
              r_nxt     = {1'b0, den};
              state_nxt = bezt_pkg::S_COEF;
            end
          end
        end
      end
      bezt_pkg::S_COEF: begin
        ax_nxt = ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          state_nxt = bezt_pkg::S_DIV;
        end
      end
      bezt_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = bezt_pkg::S_EVAL;
        end
      end
      bezt_pkg::S_EVAL: begin
        step_nxt = step_r + 5'd1;
        if (grp == 3'd4) begin
          step_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = bezt_pkg::S_OUT;
        end
      end
      bezt_pkg::S_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_r.span_last) begin
            state_nxt = bezt_pkg::S_IDLE;
          end else begin
            // Advance t by the divided step, carrying the remainder.
            i_nxt     = i_r + IDX_W'(1);
            q_nxt     = q_r + div_quo + TW'(r_over);
            r_nxt     = r_over ? 8'(r_sum - {1'b0, d2}) : r_sum[7:0];
            state_nxt = bezt_pkg::S_EVAL;
          end
        end
      end
      default: begin
        state_nxt = bezt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bezt_pkg::S_IDLE;
      spp_r       <= bezt_pkg::SPP_RESET;
      psa_r       <= '0;
      anchor_r    <= 1'b0;
      ax_r        <= '0;
      step_r      <= '0;
      i_r         <= '0;
      q_r         <= '0;
      r_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        spp_r <= cfg_wdata;
      end
      psa_r       <= psa_nxt;
      anchor_r    <= anchor_nxt;
      ax_r        <= ax_nxt;
      step_r      <= step_nxt;
      i_r         <= i_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_data.segment_start) begin
        pt_r[0][0] <= in_data.x_coord;
        pt_r[0][1] <= in_data.y_coord;
        pt_r[0][2] <= in_data.z_coord;
      end else if (anchor_r) begin
        pt_r[slot][0] <= in_data.x_coord;
        pt_r[slot][1] <= in_data.y_coord;
        pt_r[slot][2] <= in_data.z_coord;
      end
    end
    if (state_r == bezt_pkg::S_COEF) begin
      ca_r[ax_r] <= a_v;
      cb_r[ax_r] <= b_v;
      cc_r[ax_r] <= c_v;
    end
    if (state_r == bezt_pkg::S_EVAL) begin
      if (grp == 3'd0 && ph == 2'd1) begin
        t2_r <= prod_rnd;
      end
      if (grp == 3'd0 && ph == 2'd3) begin
        t3_r <= prod_rnd;
      end
      if (grp >= 3'd1 && grp <= 3'd3) begin
        case (ph)
          2'd1:    acc_r <= SW'(prod_r);
          2'd2:    acc_r <= acc_r + SW'(prod_r);
          2'd3:    sum_r <= acc_r + SW'(prod_r);
          default: acc_r <= acc_r;
        endcase
      end
      // Finish the previous axis.
      if (grp >= 3'd2 && ph == 2'd0) begin
        case (grp)
          3'd2:    out_r.x_out <= fin_sat;
          3'd3:    out_r.y_out <= fin_sat;
          3'd4:    out_r.z_out <= fin_sat;
          default: out_r.z_out <= out_r.z_out;
        endcase
      end
      if (grp == 3'd4) begin
        out_r.span_last <= is_last;
      end
    end
    // Span end becomes the next anchor.
    if (state_r == bezt_pkg::S_OUT && out_acc && out_r.span_last) begin
      pt_r[0][0] <= pt_r[3][0];
      pt_r[0][1] <= pt_r[3][1];
      pt_r[0][2] <= pt_r[3][2];
    end
  end

  `CBT_ASSERT_IMPL(a_busy_blocks_input, clk, rst_n, out_valid, in_stall, "input open while a sample is pending")
  `CBT_ASSERT_IMPL(a_eval_after_div, clk, rst_n, state_r == bezt_pkg::S_EVAL, div_done, "sample evaluated before step division finished")
  `CBT_ASSERT_NEXT(a_last_frees_input, clk, rst_n, out_valid && !out_stall && out_data.span_last, !in_stall, "input still stalled after final sample")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for cubic_bezier_tessellator: control points in, checked curve samples out.
module testbench;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int MAX_N        = 64;
  localparam int SETTLE       = 40;
  localparam int SHOWN_ERRORS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bezt_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bezt_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [bezt_pkg::CNT_W-1:0] cfg_wdata = '0;

  // Predictor state
  int unsigned sample_count;
  longint      ctrl_pts[4][3];
  int unsigned pts_since_anchor;
  bit          segment_open;

  bezt_pkg::out_beat_t exp_samples[$];
  int unsigned errors, samples_checked, spans_predicted, points_sent, cycles;
  int unsigned hold_cycles;
  bit          quiet_mode;

  cubic_bezier_tessellator #(.MAX_SAMPLES(MAX_N)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, exp_samples.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [bezt_pkg::COORD_W-1:0] clamp_coord(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[bezt_pkg::COORD_W-1:0];
  endfunction

  // Take one control point; queue the samples of a completed span.
  task automatic predict_point(bezt_pkg::in_beat_t p);
    longint pt[3];
    longint ca[3], cb[3], cc[3];
    longint den, t, t2, t3, s;
    int unsigned n, slot;
    bezt_pkg::out_beat_t r;
    pt[0] = p.x_coord; pt[1] = p.y_coord; pt[2] = p.z_coord;
    if (p.segment_start) begin
      for (int k = 0; k < 3; k++) ctrl_pts[0][k] = pt[k];
      pts_since_anchor = 0;
      segment_open = 1'b1;
      return;
    end
    if (!segment_open) return;
    slot = pts_since_anchor + 1;
    for (int k = 0; k < 3; k++) ctrl_pts[slot][k] = pt[k];
    pts_since_anchor = slot;
    if (slot < 3) return;
    n = sample_count;
    if (n < 2) n = 2;
    if (n > MAX_N) n = MAX_N;
    for (int k = 0; k < 3; k++) begin
      cc[k] = 3 * (ctrl_pts[1][k] - ctrl_pts[0][k]);
      cb[k] = 3 * (ctrl_pts[2][k] - ctrl_pts[1][k]) - cc[k];
      ca[k] = ctrl_pts[3][k] - ctrl_pts[0][k] - cc[k] - cb[k];
    end
    den = n - 1;
    for (int i = 0; i < n; i++) begin
      t  = (i * 64'sd131072 + den) / (2 * den);
      t2 = (t * t + 32768) >>> 16;
      t3 = (t2 * t + 32768) >>> 16;
      s = round_q16(ca[0] * t3 + cb[0] * t2 + cc[0] * t);
      r.x_out = clamp_coord(ctrl_pts[0][0] + s);
      s = round_q16(ca[1] * t3 + cb[1] * t2 + cc[1] * t);
      r.y_out = clamp_coord(ctrl_pts[0][1] + s);
      s = round_q16(ca[2] * t3 + cb[2] * t2 + cc[2] * t);
      r.z_out = clamp_coord(ctrl_pts[0][2] + s);
      r.span_last = (i == n - 1);
      exp_samples = {exp_samples, r};
    end
    for (int k = 0; k < 3; k++) ctrl_pts[0][k] = ctrl_pts[3][k];
    pts_since_anchor = 0;
    spans_predicted++;
  endtask

  task automatic report_mismatch(string what, bezt_pkg::out_beat_t want,
                                 bezt_pkg::out_beat_t got);
    errors++;
    if (errors <= SHOWN_ERRORS)
      $display("[%0d] %s: expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
               cycles, what, want.x_out, want.y_out, want.z_out, want.span_last,
               got.x_out, got.y_out, got.z_out, got.span_last);
  endtask

  // Check every accepted sample against the oldest expectation.
  always @(posedge clk) begin
    bezt_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      samples_checked++;
      if (exp_samples.size() == 0) begin
        report_mismatch("unexpected sample", '0, out_data);
      end else begin
        want = exp_samples.pop_front();
        if (out_data.x_out != want.x_out) report_mismatch("x_out", want, out_data);
        if (out_data.y_out != want.y_out) report_mismatch("y_out", want, out_data);
        if (out_data.z_out != want.z_out) report_mismatch("z_out", want, out_data);
        if (out_data.span_last != want.span_last) report_mismatch("span_last", want, out_data);
      end
    end
  end

  // Receiver stalls: mostly short, occasionally long, held solid on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      hold_cycles = $urandom_range(20, 120);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat and hold it until accepted.
  task automatic send_point(bezt_pkg::in_beat_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    points_sent++;
    predict_point(p);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sample_count(logic [bezt_pkg::CNT_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sample_count = 32'(v);
  endtask

  function automatic bezt_pkg::in_beat_t make_point(bit start, longint x, longint y, longint z);
    bezt_pkg::in_beat_t p;
    p.x_coord = x[bezt_pkg::COORD_W-1:0];
    p.y_coord = y[bezt_pkg::COORD_W-1:0];
    p.z_coord = z[bezt_pkg::COORD_W-1:0];
    p.segment_start = start;
    return p;
  endfunction

  // Full-range coordinates half the time, small values near zero otherwise.
  function automatic bezt_pkg::in_beat_t random_point(bit start);
    bezt_pkg::in_beat_t p;
    p.x_coord = bezt_pkg::COORD_W'($urandom);
    p.y_coord = bezt_pkg::COORD_W'($urandom);
    p.z_coord = bezt_pkg::COORD_W'($urandom);
    p.segment_start = start;
    if ($urandom_range(0, 1)) begin
      p.x_coord = bezt_pkg::COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      p.y_coord = bezt_pkg::COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      p.z_coord = bezt_pkg::COORD_W'($signed($urandom_range(0, 8191)) - 4096);
    end
    return p;
  endfunction

  task automatic random_segment(int unsigned spans);
    send_point(random_point(1'b1));
    for (int i = 0; i < 3 * spans; i++) begin
      // drop in a restart now and then
      if ($urandom_range(0, 40) == 0) send_point(random_point(1'b1));
      else send_point(random_point(1'b0));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_point(random_point(1'b0));
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd8388607;
    mn = -64'sd8388608;
    // no segment open: dropped
    send_point(make_point(1'b0, 5, 6, 7));
    send_point(make_point(1'b0, mx, mn, 0));
    // default count, saturating span from the extremes
    send_point(make_point(1'b1, mn, mx, 0));
    send_point(make_point(1'b0, mx, mn, mx));
    send_point(make_point(1'b0, mn, mx, mn));
    send_point(make_point(1'b0, mx, mn, mx));
    // chained span shares the end point
    send_point(make_point(1'b0, 0, 0, 0));
    send_point(make_point(1'b0, 256, -256, 1));
    send_point(make_point(1'b0, -1, 1, -128));
    // restart inside a span discards the partial span
    send_point(make_point(1'b0, 1000, 1000, 1000));
    send_point(make_point(1'b1, -1, -1, -1));
    send_point(make_point(1'b0, 100, 200, 300));
    send_point(make_point(1'b0, -300, -200, -100));
    send_point(make_point(1'b0, mx, mx, mx));
    write_sample_count(7'd0);
    send_point(make_point(1'b1, 10, 20, 30));
    repeat (3) send_point(random_point(1'b0));
    write_sample_count(7'd1);
    repeat (3) send_point(random_point(1'b0));
    write_sample_count(7'd127);
    repeat (3) send_point(random_point(1'b0));
    write_sample_count(7'd65);
    repeat (3) send_point(random_point(1'b0));
    write_sample_count(7'd64);
    send_point(make_point(1'b1, mn, mn, mn));
    repeat (3) send_point(make_point(1'b0, mx, mx, mx));
  endtask

  task automatic test_random();
    logic [bezt_pkg::CNT_W-1:0] v;
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: v = 7'd2;
        1: v = 7'($urandom_range(2, 12));
        2: v = 7'($urandom_range(0, 127));
        default: v = 7'($urandom_range(3, 24));
      endcase
      write_sample_count(v);
      quiet_mode = (ph == 5);
      for (int s = 0; s < 4; s++) random_segment($urandom_range(1, 3));
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    write_sample_count(7'd8);
    hold_cycles = 800;
    send_point(random_point(1'b1));
    repeat (12) send_point(random_point(1'b0));
  endtask

  task automatic test_pause_then_burst();
    wait_drained();
    quiet_mode = 1'b1;
    random_segment(3);
    quiet_mode = 1'b0;
  endtask

  initial begin
    sample_count = 32'(bezt_pkg::SPP_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_pause_then_burst();
    wait_drained();
    $display("%0d points sent, %0d spans predicted, %0d samples checked, %0d errors",
             points_sent, spans_predicted, samples_checked, errors);
    $display("covered: dropped points, restarts, shared ends, clamped counts, saturation, stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
